### rtl/core/riff_avi_fourcc_probe_unit_macros.svh
// Assertion macros for the RIFF/AVI fourcc probe checker.
`ifndef RIFF_AVI_FOURCC_PROBE_UNIT_MACROS_SVH
`define RIFF_AVI_FOURCC_PROBE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RIFFAVI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("riffavi check failed");

// Next-cycle implication, disabled during reset.
`define RIFFAVI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("riffavi check failed");

`endif

### rtl/core/riffavi_pkg.sv
// Package with tag constants, status codes and widths of the RIFF/AVI fourcc probe.
`default_nettype none

package riffavi_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_AVI  = 32'h4156_4920;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_HDRL = 32'h6864_726C;
    localparam logic [31:0] TAG_STRL = 32'h7374_726C;
    localparam logic [31:0] TAG_STRF = 32'h7374_7266;
    localparam logic [31:0] TAG_STRH = 32'h7374_7268;
    localparam logic [31:0] TAG_IAVS = 32'h6961_7673;
    localparam logic [31:0] TAG_IVAS = 32'h6976_6173;
    localparam logic [31:0] STRF_OFFSET = 32'd16;

    localparam int CODE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_NOT_RIFF = 2'd1,
        ST_NOT_AVI  = 2'd2,
        ST_NO_CODE  = 2'd3
    } status_t;

endpackage

`default_nettype wire

### rtl/core/riff_avi_fourcc_probe_unit.sv
// Top level of the RIFF/AVI fourcc probe: byte-wise chunk walker with a two-deep result buffer.
`default_nettype none

// Takes a RIFF/AVI file one byte per beat (s_tlast on the final byte) and returns one
// result beat per file: the codec fourcc of the video stream, or a status for a bad
// header or an end of file without a fourcc. Every byte is handled in the cycle it is
// accepted, so the block sustains one byte per clock while the skid register is empty;
// the only limit is the result side, where an output register plus a skid register let
// bytes keep flowing while one result waits. Bytes after the answer are dropped until
// s_tlast, which rearms the parser. m_tdata: [31:0] found_code, [33:32] status, [39:34] zero.
module riff_avi_fourcc_probe_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [riffavi_pkg::M_DATA_W-1:0] m_tdata  // found_code, status, zero pad
);

    typedef enum logic [3:0] {
        PH_RIFF      = 4'd0,
        PH_FSIZE     = 4'd1,
        PH_FORM      = 4'd2,
        PH_TAG       = 4'd3,
        PH_SIZE      = 4'd4,
        PH_SUBTAG    = 4'd5,
        PH_STRHTYPE  = 4'd6,
        PH_CODE      = 4'd7,
        PH_SKIP_TAG  = 4'd8,
        PH_SKIP_CODE = 4'd9,
        PH_DONE      = 4'd10
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [1:0]  index_reg,  index_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] size_reg,   size_next;
    logic [31:0] skip_reg,   skip_next;
    logic        answer_reg, answer_next;

    logic                  out_valid_reg;
    logic [riffavi_pkg::M_DATA_W-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [riffavi_pkg::M_DATA_W-1:0] skid_data_reg;

    logic        accept;
    logic        drain;
    logic        word_phase;
    logic        full;
    logic [31:0] gathered;
    logic [31:0] size_skip;
    logic [31:0] body_skip;
    logic        emit;
    logic [31:0] emit_code;
    riffavi_pkg::status_t emit_status;
    logic [riffavi_pkg::M_DATA_W-1:0] emit_data;

    assign accept   = s_tvalid && s_tready;
    assign drain    = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign word_phase = (phase_reg <= PH_CODE);
    assign full       = word_phase && (index_reg == 2'd3);
    assign gathered   = (phase_reg == PH_SIZE) ? {s_tdata, gather_reg[31:8]}
                                               : {gather_reg[23:0], s_tdata};
    assign size_skip  = gathered + {31'd0, gathered[0]};
    assign body_skip  = size_reg + {31'd0, size_reg[0]} - 32'd4;

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        gather_next = gather_reg;
        tag_next    = tag_reg;
        size_next   = size_reg;
        skip_next   = skip_reg;
        answer_next = answer_reg;
        emit        = 1'b0;
        emit_code   = '0;
        emit_status = riffavi_pkg::ST_FOUND;

        if (word_phase) begin
            index_next  = index_reg + 2'd1;
            gather_next = gathered;
        end

        if (full) begin
            gather_next = '0;
            unique case (phase_reg)
                PH_RIFF: begin
                    if (gathered != riffavi_pkg::TAG_RIFF) begin
                        emit        = 1'b1;
                        emit_status = riffavi_pkg::ST_NOT_RIFF;
                    end else begin
                        phase_next = PH_FSIZE;
                    end
                end
                PH_FSIZE: phase_next = PH_FORM;
                PH_FORM: begin
                    if (gathered != riffavi_pkg::TAG_AVI) begin
                        emit        = 1'b1;
                        emit_status = riffavi_pkg::ST_NOT_AVI;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG: begin
                    tag_next   = gathered;
                    phase_next = PH_SIZE;
                end
                PH_SIZE: begin
                    size_next = gathered;
                    if (tag_reg == riffavi_pkg::TAG_LIST) begin
                        phase_next = PH_SUBTAG;
                    end else if (tag_reg == riffavi_pkg::TAG_STRF) begin
                        skip_next  = riffavi_pkg::STRF_OFFSET;
                        phase_next = PH_SKIP_CODE;
                    end else if (tag_reg == riffavi_pkg::TAG_STRH) begin
                        phase_next = PH_STRHTYPE;
                    end else if (size_skip == '0) begin
                        phase_next = PH_TAG;
                    end else begin
                        skip_next  = size_skip;
                        phase_next = PH_SKIP_TAG;
                    end
                end
                PH_SUBTAG, PH_STRHTYPE: begin
                    if ((phase_reg == PH_SUBTAG) &&
                        (gathered == riffavi_pkg::TAG_HDRL ||
                         gathered == riffavi_pkg::TAG_STRL)) begin
                        phase_next = PH_TAG;
                    end else if ((phase_reg == PH_STRHTYPE) &&
                                 (gathered == riffavi_pkg::TAG_IAVS ||
                                  gathered == riffavi_pkg::TAG_IVAS)) begin
                        phase_next = PH_CODE;
                    end else if (body_skip == '0) begin
                        phase_next = PH_TAG;
                    end else begin
                        skip_next  = body_skip;
                        phase_next = PH_SKIP_TAG;
                    end
                end
                PH_CODE: begin
                    emit      = 1'b1;
                    emit_code = gathered;
                end
                default: ;
            endcase
        end else if (phase_reg == PH_SKIP_TAG || phase_reg == PH_SKIP_CODE) begin
            skip_next = skip_reg - 32'd1;
            if (skip_reg == 32'd1) begin
                phase_next = (phase_reg == PH_SKIP_CODE) ? PH_CODE : PH_TAG;
            end
        end

        if (emit) begin
            answer_next = 1'b1;
            phase_next  = PH_DONE;
        end else if (s_tlast && !answer_reg) begin
            emit = 1'b1;
            if (phase_reg == PH_RIFF) begin
                emit_status = riffavi_pkg::ST_NOT_RIFF;
            end else if (phase_reg == PH_FSIZE || phase_reg == PH_FORM) begin
                emit_status = riffavi_pkg::ST_NOT_AVI;
            end else begin
                emit_status = riffavi_pkg::ST_NO_CODE;
            end
        end

        if (s_tlast) begin
            phase_next  = PH_RIFF;
            index_next  = '0;
            gather_next = '0;
            tag_next    = '0;
            size_next   = '0;
            skip_next   = '0;
            answer_next = 1'b0;
        end
    end

    assign emit_data = {{(riffavi_pkg::M_DATA_W - riffavi_pkg::CODE_W
                          - riffavi_pkg::STATUS_W){1'b0}},
                        emit_status, emit_code};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RIFF;
            index_reg  <= '0;
            gather_reg <= '0;
            tag_reg    <= '0;
            size_reg   <= '0;
            skip_reg   <= '0;
            answer_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            gather_reg <= gather_next;
            tag_reg    <= tag_next;
            size_reg   <= size_next;
            skip_reg   <= skip_next;
            answer_reg <= answer_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (drain) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg || drain) begin
                out_data_reg  <= emit_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= emit_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (drain) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/riffavi_checker.sv
// Port-level checker for the RIFF/AVI fourcc probe, bound to the top level.
`default_nettype none
`include "riff_avi_fourcc_probe_unit_macros.svh"

module riffavi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [riffavi_pkg::M_DATA_W-1:0] m_tdata
);

    logic [riffavi_pkg::STATUS_W-1:0] status;
    logic [riffavi_pkg::CODE_W-1:0]   code;
    logic                              in_beat;

    assign status  = m_tdata[riffavi_pkg::CODE_W +: riffavi_pkg::STATUS_W];
    assign code    = m_tdata[riffavi_pkg::CODE_W-1:0];
    assign in_beat = s_tvalid && s_tready;

    `RIFFAVI_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid,
        m_tdata[riffavi_pkg::M_DATA_W-1:riffavi_pkg::CODE_W+riffavi_pkg::STATUS_W] == '0)
    `RIFFAVI_ASSERT_NOW(a_code_zero_on_error, aclk, aresetn,
        m_tvalid && status != riffavi_pkg::ST_FOUND, code == '0)
    `RIFFAVI_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `RIFFAVI_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready && !in_beat,
        m_tvalid && $stable(m_tdata))

endmodule

bind riff_avi_fourcc_probe_unit riffavi_checker u_riffavi_checker (.*);

`default_nettype wire

### tb/tb_riff_avi_fourcc_probe_unit.sv
// Testbench for riff_avi_fourcc_probe_unit: random and directed files checked by a chunk-walk scoreboard.
`default_nettype none

module tb_riff_avi_fourcc_probe_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
    localparam logic [31:0] TAG_AVIX = 32'h4156_4958;
    localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;
    localparam logic [31:0] TAG_MOVI = 32'h6D6F_7669;
    localparam logic [31:0] TAG_VIDS = 32'h7669_6473;
    localparam logic [31:0] TAG_DVSD = 32'h6476_7364;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 475;
    localparam int PHASE_FILES = 12;

    typedef enum logic [3:0] {
        WALK_RIFF, WALK_FSIZE, WALK_FORM, WALK_TAG, WALK_SIZE, WALK_SUBTAG,
        WALK_STRHTYPE, WALK_CODE, WALK_SKIP_TAG, WALK_SKIP_CODE, WALK_DONE
    } walk_phase_t;

    typedef struct packed {
        riffavi_pkg::status_t status;
        logic [31:0]          code;
    } fourcc_result_t;

    class fourcc_scoreboard;
        walk_phase_t    phase;
        logic [1:0]     idx;
        logic [31:0]    gather;
        logic [31:0]    tag;
        logic [31:0]    size;
        logic [31:0]    skip;
        bit             answered;
        fourcc_result_t pending[$];
        int             errors;

        function new();
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase = WALK_RIFF;
            idx = 2'd0;
            gather = 32'd0;
            tag = 32'd0;
            size = 32'd0;
            skip = 32'd0;
            answered = 1'b0;
        endfunction

        function void begin_skip(logic [31:0] len, bit to_code);
            if (len == 32'd0) begin
                phase = to_code ? WALK_CODE : WALK_TAG;
            end else begin
                skip = len;
                phase = to_code ? WALK_SKIP_CODE : WALK_SKIP_TAG;
            end
        endfunction

        task mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void note_byte(logic [7:0] b, bit is_last);
            walk_phase_t          ph;
            bit                   full;
            bit                   emit;
            logic [31:0]          w;
            logic [31:0]          pad;
            logic [31:0]          code;
            riffavi_pkg::status_t st;
            fourcc_result_t       r;
            ph = phase;
            full = 1'b0;
            emit = 1'b0;
            code = 32'd0;
            st = riffavi_pkg::ST_FOUND;
            if (ph <= WALK_CODE) begin
                if (ph == WALK_SIZE)
                    gather = {b, gather[31:8]};
                else
                    gather = {gather[23:0], b};
                idx = idx + 2'd1;
                full = (idx == 2'd0);
            end
            if (full) begin
                w = gather;
                pad = {31'd0, size[0]};
                case (ph)
                    WALK_RIFF: begin
                        if (w != riffavi_pkg::TAG_RIFF) begin
                            emit = 1'b1;
                            st = riffavi_pkg::ST_NOT_RIFF;
                        end else begin
                            phase = WALK_FSIZE;
                        end
                    end
                    WALK_FSIZE: phase = WALK_FORM;
                    WALK_FORM: begin
                        if (w != riffavi_pkg::TAG_AVI) begin
                            emit = 1'b1;
                            st = riffavi_pkg::ST_NOT_AVI;
                        end else begin
                            phase = WALK_TAG;
                        end
                    end
                    WALK_TAG: begin
                        tag = w;
                        phase = WALK_SIZE;
                    end
                    WALK_SIZE: begin
                        size = w;
                        pad = {31'd0, w[0]};
                        if (tag == riffavi_pkg::TAG_LIST)
                            phase = WALK_SUBTAG;
                        else if (tag == riffavi_pkg::TAG_STRF)
                            begin_skip(riffavi_pkg::STRF_OFFSET, 1'b1);
                        else if (tag == riffavi_pkg::TAG_STRH)
                            phase = WALK_STRHTYPE;
                        else
                            begin_skip(w + pad, 1'b0);
                    end
                    WALK_SUBTAG: begin
                        if (w != riffavi_pkg::TAG_HDRL && w != riffavi_pkg::TAG_STRL)
                            begin_skip(size - 32'd4 + pad, 1'b0);
                        else
                            phase = WALK_TAG;
                    end
                    WALK_STRHTYPE: begin
                        if (w == riffavi_pkg::TAG_IAVS || w == riffavi_pkg::TAG_IVAS)
                            phase = WALK_CODE;
                        else
                            begin_skip(size + pad - 32'd4, 1'b0);
                    end
                    default: begin
                        emit = 1'b1;
                        code = w;
                    end
                endcase
                gather = 32'd0;
            end else if (ph == WALK_SKIP_TAG || ph == WALK_SKIP_CODE) begin
                skip = skip - 32'd1;
                if (skip == 32'd0)
                    phase = (ph == WALK_SKIP_CODE) ? WALK_CODE : WALK_TAG;
            end
            if (emit) begin
                answered = 1'b1;
                phase = WALK_DONE;
            end else if (is_last && !answered) begin
                emit = 1'b1;
                code = 32'd0;
                if (ph == WALK_RIFF)
                    st = riffavi_pkg::ST_NOT_RIFF;
                else if (ph == WALK_FSIZE || ph == WALK_FORM)
                    st = riffavi_pkg::ST_NOT_AVI;
                else
                    st = riffavi_pkg::ST_NO_CODE;
            end
            if (emit) begin
                r.code = code;
                r.status = st;
                pending.push_back(r);
            end
            if (is_last)
                clear_walk();
        endfunction

        task check_beat(logic [riffavi_pkg::M_DATA_W-1:0] beat);
            fourcc_result_t want;
            if (pending.size() == 0) begin
                mismatch($sformatf("result %h with nothing expected", beat));
                return;
            end
            want = pending.pop_front();
            if (beat[31:0] !== want.code)
                mismatch($sformatf("found_code %h, expected %h", beat[31:0], want.code));
            if (beat[33:32] !== want.status)
                mismatch($sformatf("status %0d, expected %0d", beat[33:32], want.status));
            if (beat[riffavi_pkg::M_DATA_W-1:34] !== '0)
                mismatch($sformatf("pad bits %h not zero",
                                   beat[riffavi_pkg::M_DATA_W-1:34]));
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata = 8'd0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [riffavi_pkg::M_DATA_W-1:0] m_tdata;

    fourcc_scoreboard sb;
    logic [7:0]       file_buf[$];
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    int               bytes_sent = 0;
    int               quiet_cycles = 0;

    riff_avi_fourcc_probe_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic void push_be(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(w[31-8*i -: 8]);
    endfunction

    function automatic void push_le(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_fill(int n);
        for (int i = 0; i < n; i++)
            file_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void push_avi_header(logic [31:0] riff_size);
        push_be(riffavi_pkg::TAG_RIFF);
        push_le(riff_size);
        push_be(riffavi_pkg::TAG_AVI);
    endfunction

    // mostly well-formed chunk walks; some noise, bad headers, truncation
    function automatic void compose_avi_file();
        int          n_chunks;
        int          kind;
        int          sz;
        int          cut;
        logic [31:0] w;
        file_buf.delete();
        if ($urandom_range(9) == 0) begin
            push_fill($urandom_range(1, 12));
            return;
        end
        w = riffavi_pkg::TAG_RIFF;
        if ($urandom_range(11) == 0)
            w = w ^ (32'd1 << $urandom_range(31));
        push_be(w);
        push_le($urandom);
        w = riffavi_pkg::TAG_AVI;
        if ($urandom_range(11) == 0)
            w = w ^ (32'd1 << $urandom_range(31));
        push_be(w);
        n_chunks = $urandom_range(0, 5);
        for (int i = 0; i < n_chunks; i++) begin
            kind = $urandom_range(9);
            sz = $urandom_range(0, 20);
            case (kind)
                2: begin
                    push_be(riffavi_pkg::TAG_LIST);
                    push_le(sz);
                    push_be($urandom_range(1) ? riffavi_pkg::TAG_HDRL
                                              : riffavi_pkg::TAG_STRL);
                end
                3: begin
                    sz = $urandom_range(3, 20);
                    push_be(riffavi_pkg::TAG_LIST);
                    push_le(sz);
                    push_be($urandom);
                    push_fill(sz - 4 + (sz & 1));
                end
                4: begin
                    sz = $urandom_range(3, 20);
                    push_be(riffavi_pkg::TAG_STRH);
                    push_le(sz);
                    push_be($urandom);
                    push_fill(sz + (sz & 1) - 4);
                end
                5: begin
                    push_be(riffavi_pkg::TAG_STRH);
                    push_le($urandom);
                    push_be($urandom_range(1) ? riffavi_pkg::TAG_IAVS
                                              : riffavi_pkg::TAG_IVAS);
                    push_be($urandom);
                end
                6: begin
                    push_be(riffavi_pkg::TAG_STRF);
                    push_le($urandom);
                    push_fill(16);
                    push_be($urandom);
                end
                7: begin
                    // size below the subtag: skip length wraps
                    push_be(riffavi_pkg::TAG_LIST);
                    push_le($urandom_range(0, 2));
                    push_be($urandom);
                end
                default: begin
                    push_be($urandom);
                    push_le(sz);
                    push_fill(sz + (sz & 1));
                end
            endcase
        end
        push_fill($urandom_range(0, 4));
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut)
                void'(file_buf.pop_back());
        end
        if (file_buf.size() == 0)
            push_fill(1);
    endfunction

    task automatic send_beat(logic [7:0] b, bit is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_beat(file_buf[i], i == file_buf.size() - 1);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        int mark;
        int files;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // end inside the first header word
        file_buf.delete();
        file_buf.push_back(8'h00);
        send_file();
        // bad RIFF word, then a last byte after the answer
        file_buf.delete();
        push_be(TAG_RIFX);
        file_buf.push_back(8'hFF);
        send_file();
        // end inside the size word
        file_buf.delete();
        push_be(riffavi_pkg::TAG_RIFF);
        push_fill(0);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'hFF);
        send_file();
        // bad form word, answer on the last byte
        file_buf.delete();
        push_be(riffavi_pkg::TAG_RIFF);
        push_le(32'hFFFF_FFFF);
        push_be(TAG_AVIX);
        send_file();
        // end inside the form word
        file_buf.delete();
        push_be(riffavi_pkg::TAG_RIFF);
        push_le(32'd0);
        file_buf.push_back(8'h41);
        file_buf.push_back(8'h56);
        send_file();
        // zero-length chunk, then strf code ending on the last byte
        file_buf.delete();
        push_avi_header(32'd0);
        push_be(TAG_JUNK);
        push_le(32'd0);
        push_be(riffavi_pkg::TAG_STRF);
        push_le(32'd20);
        push_fill(16);
        push_be(TAG_DVSD);
        send_file();
        // entered LIST, skipped odd LIST, empty strh skip, iavs code, trailer
        file_buf.delete();
        push_avi_header($urandom);
        push_be(riffavi_pkg::TAG_LIST);
        push_le(32'd0);
        push_be(riffavi_pkg::TAG_HDRL);
        push_be(riffavi_pkg::TAG_LIST);
        push_le(32'd5);
        push_be(TAG_MOVI);
        push_fill(2);
        push_be(riffavi_pkg::TAG_STRH);
        push_le(32'd4);
        push_be(TAG_VIDS);
        push_be(riffavi_pkg::TAG_STRH);
        push_le(32'd40);
        push_be(riffavi_pkg::TAG_IAVS);
        push_be(TAG_DVSD);
        file_buf.push_back(8'h00);
        send_file();
        // end inside a skipped chunk without a code
        file_buf.delete();
        push_avi_header(32'd0);
        push_be(TAG_JUNK);
        push_le(32'd3);
        push_fill(4);
        send_file();

        for (int p = 0; p < 4; p++) begin
            wait_results_drained();
            case (p)
                0: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 62;
                end
                default: begin
                    src_idle_pct = 11;
                    snk_stall_pct = 11;
                end
            endcase
            mark = bytes_sent;
            files = 0;
            while (bytes_sent - mark < PHASE_BYTES || files < PHASE_FILES) begin
                compose_avi_file();
                send_file();
                files++;
            end
        end

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.mismatch($sformatf("%0d expected results never came", sb.pending.size()));
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
